// ===== hdl/axis_angle_rotation_matrix_defines.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, ignored while reset is low.
`define AARM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is low.
`define AARM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/aarm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

	localparam int TURN_UNITS  = 46080;
	localparam int GAIN_Q30    = 652032875;
	localparam int TABLE_LEN   = 24;
	localparam int RECIP45     = 93207;
	localparam int RECIP_SHIFT = 22;
	localparam int SQRT_STAGES = 16;
	localparam int DIV_STAGES  = 16;
	localparam int CORE_STAGES = SQRT_STAGES + DIV_STAGES;

	localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Binary-angle fraction for a residue of 0..44 in units of 2^22 / 45
	typedef logic [63:0][21:0] frac_tab_t;

	function automatic frac_tab_t build_frac_tab();
		frac_tab_t tab;
		longint    num;
		for (int b = 0; b < 64; b++) begin
			num = (longint'(b) << 22) + 64'sd22;
			tab[b] = (b < 45) ? 22'(num / 45) : 22'd0;
		end
		return tab;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
		logic               flip;
		logic               zero;
		logic [31:0]        n2;
		logic [35:0]        srem;
		logic [31:0]        root;
		logic [2:0]         neg;
		logic [2:0][15:0]   mag;
		logic [2:0][33:0]   drem;
		logic [2:0][30:0]   quo;
	} core_t;

	typedef struct packed {
		logic [8:0][15:0] m;
		logic             zero_axis;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/aarm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface aarm_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [19:0] angle;

	modport source(output valid, axis_x, axis_y, axis_z, angle, input ready);
	modport sink(input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aarm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] m_row1_col1;
	logic signed [15:0] m_row1_col2;
	logic signed [15:0] m_row1_col3;
	logic signed [15:0] m_row2_col1;
	logic signed [15:0] m_row2_col2;
	logic signed [15:0] m_row2_col3;
	logic signed [15:0] m_row3_col1;
	logic signed [15:0] m_row3_col2;
	logic signed [15:0] m_row3_col3;
	logic               zero_axis;

	modport source(output valid, m_row1_col1, m_row1_col2, m_row1_col3, m_row2_col1,
		m_row2_col2, m_row2_col3, m_row3_col1, m_row3_col2, m_row3_col3, zero_axis,
		input ready);
	modport sink(input valid, m_row1_col1, m_row1_col2, m_row1_col3, m_row2_col1,
		m_row2_col2, m_row2_col3, m_row3_col1, m_row3_col2, m_row3_col3, zero_axis,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the skid is empty; 4 angle/norm stages, a
// 32-stage core (16 root stages of two digits, then 16 divider stages of two bits,
// CORDIC alongside) and 4 product stages. A two-entry output (register plus skid)
// decouples a stall.
// Reset clears all valid bits and the output and skid flags; data is not reset.
`include "axis_angle_rotation_matrix_defines.svh"
module axis_angle_rotation_matrix #(
	parameter int CORDIC_STEPS  = 16,
	parameter int FRACTION_BITS = 14
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	aarm_in_if.sink     in_item,
	aarm_out_if.source  out_item
);

	localparam int T  = aarm_pkg::TURN_UNITS;
	localparam int NC = aarm_pkg::CORE_STAGES;
	localparam int SH = 60 - FRACTION_BITS;
	localparam logic signed [67:0] RND   = 68'sd1 <<< (SH - 1);
	localparam logic signed [67:0] ONE_Q = 68'sd1 <<< FRACTION_BITS;
	localparam logic [63:0]        ONE_W = 64'd1 << FRACTION_BITS;
	localparam logic [15:0]        ONE_OUT = ONE_W[15:0];

	function automatic logic [15:0] finish(logic signed [67:0] v);
		logic signed [67:0] r;
		r = (v + RND) >>> SH;
		if (r > ONE_Q) begin
			r = ONE_Q;
		end else if (r < -ONE_Q) begin
			r = -ONE_Q;
		end
		return r[15:0];
	endfunction

	logic en;
	logic sk_v_q, out_v_q;
	aarm_pkg::res_t sk_q, out_q;

	// hold the whole pipe only while the skid is occupied
	assign en = !sk_v_q;
	assign in_item.ready = en;

	// stage 1: squares, first two reduction steps
	logic               v_s1;
	logic [30:0]        sq_s1 [3];
	logic [20:0]        ang_s1;
	logic               zero_s1;
	logic [2:0]         neg_s1;
	logic [2:0][15:0]   mag_s1;

	logic signed [21:0] ang_full;
	logic [20:0]        a0, a1, a2;
	logic signed [31:0] sqx, sqy, sqz;
	logic [16:0]        mx, my, mz;

	always_comb begin
		ang_full = 22'(in_item.angle) + 22'sd552960;
		a0 = ang_full[20:0];
		a1 = (a0 >= 21'(16 * T)) ? a0 - 21'(16 * T) : a0;
		a2 = (a1 >= 21'(8 * T)) ? a1 - 21'(8 * T) : a1;
		sqx = in_item.axis_x * in_item.axis_x;
		sqy = in_item.axis_y * in_item.axis_y;
		sqz = in_item.axis_z * in_item.axis_z;
		mx = in_item.axis_x[15] ? 17'd0 - 17'(in_item.axis_x) : 17'(in_item.axis_x);
		my = in_item.axis_y[15] ? 17'd0 - 17'(in_item.axis_y) : 17'(in_item.axis_y);
		mz = in_item.axis_z[15] ? 17'd0 - 17'(in_item.axis_z) : 17'(in_item.axis_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1[0] <= sqx[30:0];
			sq_s1[1] <= sqy[30:0];
			sq_s1[2] <= sqz[30:0];
			ang_s1   <= a2;
			zero_s1  <= (in_item.axis_x == 16'sd0) && (in_item.axis_y == 16'sd0) &&
				(in_item.axis_z == 16'sd0);
			neg_s1   <= {in_item.axis_z[15], in_item.axis_y[15], in_item.axis_x[15]};
			mag_s1   <= {mz[15:0], my[15:0], mx[15:0]};
		end
	end

	// stage 2: squared norm, rest of the reduction
	logic               v_s2;
	logic [31:0]        n2_s2;
	logic [15:0]        r_s2;
	logic               zero_s2;
	logic [2:0]         neg_s2;
	logic [2:0][15:0]   mag_s2;
	logic [20:0]        b0, b1, b2;

	always_comb begin
		b0 = (ang_s1 >= 21'(4 * T)) ? ang_s1 - 21'(4 * T) : ang_s1;
		b1 = (b0 >= 21'(2 * T)) ? b0 - 21'(2 * T) : b0;
		b2 = (b1 >= 21'(T)) ? b1 - 21'(T) : b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s2   <= 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
			r_s2    <= b2[15:0];
			zero_s2 <= zero_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
		end
	end

	// stage 3: whole part of residue / 45 by reciprocal
	logic               v_s3;
	logic [31:0]        n2_s3;
	logic [15:0]        r_s3;
	logic [9:0]         quo45_s3;
	logic               zero_s3;
	logic [2:0]         neg_s3;
	logic [2:0][15:0]   mag_s3;
	logic [33:0]        rprod;

	assign rprod = 34'(r_s2) * 34'(aarm_pkg::RECIP45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s3    <= n2_s2;
			r_s3     <= r_s2;
			quo45_s3 <= rprod[aarm_pkg::RECIP_SHIFT +: 10];
			zero_s3  <= zero_s2;
			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
		end
	end

	// stage 4: binary angle, quadrant fold, core entry
	aarm_pkg::core_t core_s [NC + 1];
	logic            core_v_s [NC + 1];
	aarm_pkg::core_t init;

	always_comb begin
		logic [15:0] rem45;
		logic [9:0]  qa;
		logic [31:0] tb;
		logic        fl;
		qa = quo45_s3;
		rem45 = r_s3 - 16'(qa) * 16'd45;
		if (rem45 >= 16'd45) begin
			qa = qa + 10'd1;
			rem45 = rem45 - 16'd45;
		end
		tb = {qa, aarm_pkg::FRAC_TAB[rem45[5:0]]};
		fl = tb[31] ^ tb[30];
		init = '0;
		init.x    = 34'sd652032875;
		init.y    = 34'sd0;
		init.z    = fl ? $signed(tb ^ 32'h80000000) : $signed(tb);
		init.flip = fl;
		init.zero = zero_s3;
		init.n2   = n2_s3;
		init.neg  = neg_s3;
		init.mag  = mag_s3;
		for (int l = 0; l < 3; l++) begin
			init.drem[l] = {3'b000, mag_s3[l], 15'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_v_s[0] <= 1'b0;
		end else if (en) begin
			core_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			core_s[0] <= init;
		end
	end

	for (genvar s = 0; s < NC; s++) begin : g_core
		aarm_stage #(
			.IDX(s),
			.CORDIC_STEPS(CORDIC_STEPS)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_in(core_v_s[s]),
			.d(core_s[s]),
			.vld_out(core_v_s[s + 1]),
			.q(core_s[s + 1])
		);
	end

	// stage 5: unit axis, sign fold, axis products
	logic               v_s5, zero_s5;
	logic signed [31:0] r_s5 [3];
	logic signed [33:0] c_s5, s_s5;
	logic signed [63:0] p_s5 [6];
	logic signed [31:0] ru [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ru[l] = core_s[NC].neg[l] ? -$signed({1'b0, core_s[NC].quo[l]}) :
				$signed({1'b0, core_s[NC].quo[l]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= core_v_s[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= core_s[NC].zero;
			r_s5    <= ru;
			c_s5    <= core_s[NC].flip ? -core_s[NC].x : core_s[NC].x;
			s_s5    <= core_s[NC].flip ? -core_s[NC].y : core_s[NC].y;
			p_s5[0] <= ru[0] * ru[0];
			p_s5[1] <= ru[1] * ru[1];
			p_s5[2] <= ru[2] * ru[2];
			p_s5[3] <= ru[0] * ru[1];
			p_s5[4] <= ru[0] * ru[2];
			p_s5[5] <= ru[1] * ru[2];
		end
	end

	// stage 6: round axis products to Q30, sine terms, one minus cosine
	logic               v_s6, zero_s6;
	logic signed [31:0] rr_s6 [6];
	logic signed [65:0] rs_s6 [3];
	logic signed [34:0] omc_s6;
	logic signed [33:0] c_s6;
	logic signed [63:0] rnd [6];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			rnd[i] = (p_s5[i] + 64'sd536870912) >>> 30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= zero_s5;
			for (int i = 0; i < 6; i++) begin
				rr_s6[i] <= rnd[i][31:0];
			end
			for (int l = 0; l < 3; l++) begin
				rs_s6[l] <= r_s5[l] * s_s5;
			end
			omc_s6 <= 35'sd1073741824 - c_s5;
			c_s6   <= c_s5;
		end
	end

	// stage 7: axis products times one minus cosine
	logic               v_s7, zero_s7;
	logic signed [66:0] t_s7 [6];
	logic signed [65:0] rs_s7 [3];
	logic signed [33:0] c_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s7 <= zero_s6;
			for (int i = 0; i < 6; i++) begin
				t_s7[i] <= rr_s6[i] * omc_s6;
			end
			rs_s7 <= rs_s6;
			c_s7  <= c_s6;
		end
	end

	// stage 8: sum in Q60, round, saturate; identity for a zero axis
	logic           v_s8;
	aarm_pkg::res_t res_s8;
	aarm_pkg::res_t res;
	logic signed [67:0] cd;

	always_comb begin
		cd = 68'(c_s7) <<< 30;
		res.m[0] = finish(68'(t_s7[0]) + cd);
		res.m[1] = finish(68'(t_s7[3]) - 68'(rs_s7[2]));
		res.m[2] = finish(68'(t_s7[4]) + 68'(rs_s7[1]));
		res.m[3] = finish(68'(t_s7[3]) + 68'(rs_s7[2]));
		res.m[4] = finish(68'(t_s7[1]) + cd);
		res.m[5] = finish(68'(t_s7[5]) - 68'(rs_s7[0]));
		res.m[6] = finish(68'(t_s7[4]) - 68'(rs_s7[1]));
		res.m[7] = finish(68'(t_s7[5]) + 68'(rs_s7[0]));
		res.m[8] = finish(68'(t_s7[2]) + cd);
		res.zero_axis = zero_s7;
		if (zero_s7) begin
			res.m = '0;
			res.m[0] = ONE_OUT;
			res.m[4] = ONE_OUT;
			res.m[8] = ONE_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8 <= res;
		end
	end

	// output register with skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (out_item.ready) begin
				sk_v_q <= 1'b0;
			end
		end else if (!out_v_q || out_item.ready) begin
			out_v_q <= v_s8;
		end else if (v_s8) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (out_item.ready) begin
				out_q <= sk_q;
			end
		end else if (!out_v_q || out_item.ready) begin
			out_q <= res_s8;
		end else begin
			sk_q <= res_s8;
		end
	end

	assign out_item.valid       = out_v_q;
	assign out_item.m_row1_col1 = out_q.m[0];
	assign out_item.m_row1_col2 = out_q.m[1];
	assign out_item.m_row1_col3 = out_q.m[2];
	assign out_item.m_row2_col1 = out_q.m[3];
	assign out_item.m_row2_col2 = out_q.m[4];
	assign out_item.m_row2_col3 = out_q.m[5];
	assign out_item.m_row3_col1 = out_q.m[6];
	assign out_item.m_row3_col2 = out_q.m[7];
	assign out_item.m_row3_col3 = out_q.m[8];
	assign out_item.zero_axis   = out_q.zero_axis;

	`AARM_ASSERT_IMP(a_skid_behind_out, clk, arst_n, sk_v_q, out_v_q)
	`AARM_ASSERT_NXT(a_skid_holds, clk, arst_n, sk_v_q && !out_item.ready, sk_v_q)
	`AARM_ASSERT_NXT(a_skid_catches, clk, arst_n,
		!sk_v_q && out_v_q && !out_item.ready && v_s8, sk_v_q)
	`AARM_ASSERT_IMP(a_zero_identity, clk, arst_n, out_v_q && out_q.zero_axis,
		out_q.m[1] == 16'd0 && out_q.m[2] == 16'd0 && out_q.m[3] == 16'd0 &&
		out_q.m[5] == 16'd0 && out_q.m[6] == 16'd0 && out_q.m[7] == 16'd0)

endmodule
`default_nettype wire

// ===== hdl/aarm_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One core stage: CORDIC rotation if IDX < CORDIC_STEPS, plus two root digits or two quotient bits per lane.
module aarm_stage #(
	parameter int IDX          = 0,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_in,
	input  wire aarm_pkg::core_t d,
	output logic                vld_out,
	output aarm_pkg::core_t     q
);

	localparam bit DO_ROT  = IDX < CORDIC_STEPS;
	localparam bit DO_SQRT = IDX < aarm_pkg::SQRT_STAGES;
	localparam bit DO_DIV  = !DO_SQRT;
	localparam int K       = DO_DIV ? IDX - aarm_pkg::SQRT_STAGES : 0;
	localparam logic signed [31:0] ATAN_VAL = (IDX < aarm_pkg::TABLE_LEN) ?
		aarm_pkg::ATAN_TURN[(IDX < aarm_pkg::TABLE_LEN) ? IDX : 0] : 32'sd0;

	aarm_pkg::core_t n;

	always_comb begin
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic [35:0]        rem;
		logic [35:0]        trial;
		logic [1:0]         pair;
		logic [33:0]        dr;
		int                 p;
		int                 b;
		n = d;
		if (DO_ROT) begin
			dx = d.y >>> IDX;
			dy = d.x >>> IDX;
			if (!d.z[31]) begin
				n.x = d.x - dx;
				n.y = d.y + dy;
				n.z = d.z - ATAN_VAL;
			end else begin
				n.x = d.x + dx;
				n.y = d.y - dy;
				n.z = d.z + ATAN_VAL;
			end
		end
		if (DO_SQRT) begin
			for (int j = 0; j < 2; j++) begin
				p = 31 - 2 * IDX - j;
				pair = (p >= 16) ? n.n2[((p >= 16) ? 2 * (p - 16) : 0) +: 2] : 2'b00;
				rem = {n.srem[33:0], pair};
				trial = {2'b00, n.root, 2'b01};
				if (rem >= trial) begin
					n.srem = rem - trial;
					n.root = {n.root[30:0], 1'b1};
				end else begin
					n.srem = rem;
					n.root = {n.root[30:0], 1'b0};
				end
			end
		end
		if (DO_DIV) begin
			for (int j = 0; j < 2; j++) begin
				b = 30 - 2 * K - j;
				if (b >= 0) begin
					for (int l = 0; l < 3; l++) begin
						// low dividend bits are the halved root
						dr = {n.drem[l][32:0], d.root[b + 1]};
						if (dr >= {2'b00, d.root}) begin
							n.drem[l] = dr - {2'b00, d.root};
							n.quo[l][b] = 1'b1;
						end else begin
							n.drem[l] = dr;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= n;
		end
	end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

	localparam int FRACTION_BITS = 14;
	localparam int CORDIC_STEPS  = 16;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int LONG_HOLD     = 300;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 60;

	localparam logic [31:0] ATAN_BAM [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	logic clk;
	logic arst_n;

	aarm_in_if  in_if();
	aarm_out_if out_if();

	axis_angle_rotation_matrix DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_if.sink),
		.out_item(out_if.source)
	);

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unit_part(longint a, logic [63:0] len);
		logic [63:0] mag;
		longint      q;
		mag = (a < 0) ? -a : a;
		q = longint'(((mag << 46) + (len >> 1)) / len);
		return (a < 0) ? -q : q;
	endfunction

	function automatic logic [15:0] round_sat(longint q60);
		longint v;
		longint one;
		one = longint'(1) << FRACTION_BITS;
		v = (q60 + (longint'(1) << (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS);
		if (v > one)
			v = one;
		if (v < -one)
			v = -one;
		return v[15:0];
	endfunction

	function automatic longint prod30(longint a, longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic aarm_pkg::res_t rotation_matrix(logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az, logic signed [19:0] ang);
		aarm_pkg::res_t res;
		longint      a_x, a_y, a_z, red, x, y, dx, dy, zz, at, c, s, omc;
		longint      rx, ry, rz, rxx, ryy, rzz, rxy, rxz, ryz;
		logic [63:0] n2, len;
		logic [31:0] bam;
		int          z;
		logic        flip;
		res = '0;
		a_x = ax;
		a_y = ay;
		a_z = az;
		n2 = a_x * a_x + a_y * a_y + a_z * a_z;
		if (n2 == 0) begin
			res.m[0] = 16'(1 << FRACTION_BITS);
			res.m[4] = 16'(1 << FRACTION_BITS);
			res.m[8] = 16'(1 << FRACTION_BITS);
			res.zero_axis = 1'b1;
			return res;
		end
		red = longint'(ang) % aarm_pkg::TURN_UNITS;
		if (red < 0)
			red += aarm_pkg::TURN_UNITS;
		bam = 32'(((64'(red) << 32) + aarm_pkg::TURN_UNITS / 2) / aarm_pkg::TURN_UNITS);
		flip = (bam[31:30] == 2'b01) || (bam[31:30] == 2'b10);
		if (flip)
			bam += 32'h80000000;
		z = signed'(bam);
		x = longint'(aarm_pkg::GAIN_Q30);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			at = (i < 24) ? longint'(ATAN_BAM[i]) : 0;
			zz = z;
			if (zz >= 0) begin
				x -= dx;
				y += dy;
				zz -= at;
			end else begin
				x += dx;
				y -= dy;
				zz += at;
			end
			z = int'(zz);
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		omc = (longint'(1) << 30) - c;
		len = root_floor(n2 << 32);
		rx = unit_part(a_x, len);
		ry = unit_part(a_y, len);
		rz = unit_part(a_z, len);
		rxx = prod30(rx, rx);
		ryy = prod30(ry, ry);
		rzz = prod30(rz, rz);
		rxy = prod30(rx, ry);
		rxz = prod30(rx, rz);
		ryz = prod30(ry, rz);
		res.m[0] = round_sat(rxx * omc + c * (longint'(1) << 30));
		res.m[1] = round_sat(rxy * omc - rz * s);
		res.m[2] = round_sat(rxz * omc + ry * s);
		res.m[3] = round_sat(rxy * omc + rz * s);
		res.m[4] = round_sat(ryy * omc + c * (longint'(1) << 30));
		res.m[5] = round_sat(ryz * omc - rx * s);
		res.m[6] = round_sat(rxz * omc - ry * s);
		res.m[7] = round_sat(ryz * omc + rx * s);
		res.m[8] = round_sat(rzz * omc + c * (longint'(1) << 30));
		return res;
	endfunction

	class matrix_scoreboard;
		aarm_pkg::res_t pending_q[$];
		int   errors;
		int   noted;

		function void note_item(logic signed [15:0] ax, logic signed [15:0] ay,
				logic signed [15:0] az, logic signed [19:0] ang);
			pending_q.push_back(rotation_matrix(ax, ay, az, ang));
			noted++;
		endfunction

		function void check_matrix(aarm_pkg::res_t got);
			aarm_pkg::res_t want;
			if (pending_q.size() == 0) begin
				$error("matrix item with no expectation waiting");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			for (int k = 0; k < 9; k++) begin
				if (got.m[k] !== want.m[k]) begin
					$error("m_row%0d_col%0d: expected %0d, got %0d", k / 3 + 1, k % 3 + 1,
						$signed(want.m[k]), $signed(got.m[k]));
					errors++;
				end
			end
			if (got.zero_axis !== want.zero_axis) begin
				$error("zero_axis: expected %0d, got %0d", want.zero_axis, got.zero_axis);
				errors++;
			end
		endfunction
	endclass

	matrix_scoreboard board = new();
	int idle_cycles;
	logic stimulus_done;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Note accepted items on both sides at the rising edge.
	always @(posedge clk) begin
		aarm_pkg::res_t got;
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				board.note_item(in_if.axis_x, in_if.axis_y, in_if.axis_z, in_if.angle);
			if (out_if.valid && out_if.ready) begin
				got.m[0] = out_if.m_row1_col1;
				got.m[1] = out_if.m_row1_col2;
				got.m[2] = out_if.m_row1_col3;
				got.m[3] = out_if.m_row2_col1;
				got.m[4] = out_if.m_row2_col2;
				got.m[5] = out_if.m_row2_col3;
				got.m[6] = out_if.m_row3_col1;
				got.m[7] = out_if.m_row3_col2;
				got.m[8] = out_if.m_row3_col3;
				got.zero_axis = out_if.zero_axis;
				board.check_matrix(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Receiver: pick a new random stall pattern periodically, and one long hold-off once
	// more than 300 items have been accepted.
	initial begin
		int  cyc;
		int  mode;
		logic held;
		out_if.ready <= 1'b0;
		cyc = 0;
		mode = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 256 == 0)
				mode = $urandom_range(0, 3);
			if (!held && board.noted > 300) begin
				held = 1'b1;
				out_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			case (mode)
				0: out_if.ready <= 1'b1;
				1: out_if.ready <= ($urandom_range(0, 1) == 1);
				2: out_if.ready <= ($urandom_range(0, 3) == 0);
				default: out_if.ready <= (cyc % 8 < 5);
			endcase
		end
	end

	task automatic send_item(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic signed [19:0] ang);
		in_if.valid  <= 1'b1;
		in_if.axis_x <= ax;
		in_if.axis_y <= ay;
		in_if.axis_z <= az;
		in_if.angle  <= ang;
		do @(posedge clk); while (!in_if.ready);
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		in_if.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_random();
		logic signed [15:0] ax, ay, az;
		int sel;
		sel = $urandom_range(0, 19);
		ax = 16'($urandom);
		ay = 16'($urandom);
		az = 16'($urandom);
		if (sel == 0) begin
			ax = 0;
			ay = 0;
			az = 0;
		end else if (sel < 5) begin
			ax = 16'($signed(5'($urandom)));
			ay = 16'($signed(5'($urandom)));
			az = 16'($signed(5'($urandom)));
		end else if (sel < 7) begin
			ay = 0;
			az = (sel == 5) ? 16'sd0 : az;
		end
		send_item(ax, ay, az, 20'($urandom));
	endtask

	initial begin
		int burst;
		in_if.valid  <= 1'b0;
		in_if.axis_x <= '0;
		in_if.axis_y <= '0;
		in_if.axis_z <= '0;
		in_if.angle  <= '0;
		stimulus_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);

		// zero axis, unit axes, extremes, quadrant boundaries, angle wrap
		send_item(0, 0, 0, 0);
		send_item(0, 0, 0, 20'sd11520);
		send_item(0, 0, 0, -20'sd524288);
		send_item(1, 0, 0, 20'sd11520);
		send_item(0, 1, 0, 20'sd11520);
		send_item(0, 0, 1, 20'sd11520);
		send_item(-1, 0, 0, 20'sd5760);
		send_item(0, 0, 1, 0);
		send_item(0, 0, 1, 20'sd23040);
		send_item(0, 0, 1, 20'sd34560);
		send_item(0, 0, 1, 20'sd46080);
		send_item(0, 0, 1, -20'sd11520);
		send_item(1, 1, 1, 20'sd15360);
		send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 20'sd524287);
		send_item(-16'sh8000, -16'sh8000, -16'sh8000, -20'sd524288);
		send_item(-16'sh8000, 16'sh7FFF, 0, 20'sd23039);
		send_item(16'sh7FFF, 0, -16'sh8000, 20'sd23041);
		send_item(3, -4, 12, 20'sd1);
		send_item(-16'sh8000, 0, 0, 20'sd11519);
		send_item(1, -16'sh8000, 1, -20'sd1);

		// wait for every result before the random part
		pause_sender(1);
		while (board.pending_q.size() != 0)
			@(negedge clk);

		for (int n = 0; n < RANDOM_ITEMS; ) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 12);
			for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++)
				send_random();
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 9));
		end
		pause_sender(1);
		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial idle_cycles = 0;

endmodule
